[hw/rtl/salc_pkg.sv]
// Shared constants, codes and controller/datapath link types for the
// set-associative LRU cache simulator. No dependencies.
package salc_pkg;

    localparam int SET_BITS_MAX = 6;
    localparam int WAYS         = 4;
    localparam int ADDR_BITS    = 64;

    localparam int SETS     = 1 << SET_BITS_MAX;
    localparam int SET_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W   = $clog2(WAYS + 1);
    localparam int TAG_W    = ADDR_BITS;
    localparam int STAMP_W  = 32;
    localparam int TOTAL_W  = 32;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic accept;
        logic probe_rd;
        logic probe_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic noop;
        logic more;
    } t_dp_st;

endpackage

[hw/rtl/set_assoc_lru_cache_sim_top.sv]
// Top level of the set-associative LRU cache simulator.
// Depends on salc_pkg, salc_ctrl, salc_dp.
//
// One request is one data access; one result follows it with per-access
// hit/miss/eviction counts and saturating totals. An access probes one
// set, or a second set as well when it crosses a block: each probe is a
// read then an update of one set row in the tag and stamp RAMs. An
// unknown command probes nothing. The input stays stalled until the result
// is loaded, so a new request is not taken before the last result is
// loaded; the result itself may wait on the output stall first.
// Configuration writes are always ready; write them only while idle.
module set_assoc_lru_cache_sim_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_address,
    input  logic [4:0]  i_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_hits_now,
    output logic [1:0]  o_misses_now,
    output logic [1:0]  o_evictions_now,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_eviction_total
);
    salc_pkg::t_dp_cmd dcmd;
    salc_pkg::t_dp_st  dst;

    assign o_cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cmd(dcmd), .i_st(dst)
    );

    salc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(i_cmd), .i_address(i_address), .i_size(i_size),
        .i_dcmd(dcmd), .o_st(dst),
        .o_hits_now(o_hits_now), .o_misses_now(o_misses_now),
        .o_evictions_now(o_evictions_now), .o_hit_total(o_hit_total),
        .o_miss_total(o_miss_total), .o_eviction_total(o_eviction_total)
    );
endmodule

[hw/rtl/salc_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/salc_ctrl.sv]
// Sequencer for the cache simulator: accept, per-probe read and update, result.
// Depends on salc_pkg.
module salc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output salc_pkg::t_dp_cmd o_cmd,
    input  salc_pkg::t_dp_st  i_st
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        n_out_valid    = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                if (i_st.noop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.probe_wr = 1'b1;
                n_state        = i_st.more ? S_READ : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> $past(r_state) == S_READ) else $error("compare without read");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !(r_out_valid && i_out_stall)) else $error("result overwritten");
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_READ) else $error("accept not followed by read");
endmodule

[hw/rtl/salc_dp.sv]
// Datapath: configuration, address split, tag/stamp RAMs, valid bits,
// hit/LRU selection and saturating totals. Depends on salc_pkg, salc_ram.
module salc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [1:0]                     i_cfg_index,
    input  logic [4:0]                     i_cfg_data,
    input  logic [1:0]                     i_cmd,
    input  logic [63:0]                    i_address,
    input  logic [4:0]                     i_size,
    input  salc_pkg::t_dp_cmd              i_dcmd,
    output salc_pkg::t_dp_st               o_st,
    output logic [2:0]                     o_hits_now,
    output logic [1:0]                     o_misses_now,
    output logic [1:0]                     o_evictions_now,
    output logic [salc_pkg::TOTAL_W-1:0]   o_hit_total,
    output logic [salc_pkg::TOTAL_W-1:0]   o_miss_total,
    output logic [salc_pkg::TOTAL_W-1:0]   o_eviction_total
);
    localparam int TW = salc_pkg::TAG_W;
    localparam int SW = salc_pkg::STAMP_W;
    localparam int NW = salc_pkg::WAYS;

    logic [2:0] r_cfg_s;
    logic [4:0] r_cfg_b;
    logic [2:0] r_cfg_e;

    logic [3:0]                   w_s;
    logic [4:0]                   w_b;
    logic [4:0]                   w_sh;
    logic [salc_pkg::ADDR_BITS-1:0] w_addr, w_blk;
    logic [salc_pkg::SET_W-1:0]   w_smask, w_set;
    logic [16:0]                  w_omask, w_off, w_end;
    logic [4:0]                   w_size;
    logic [salc_pkg::WCNT_W-1:0]  w_ways;

    logic [1:0]                   r_cmd;
    logic                         r_noop, r_cross, r_wrap, r_first;
    logic [TW-1:0]                r_tag;
    logic [salc_pkg::SET_W-1:0]   r_set;
    logic [salc_pkg::WCNT_W-1:0]  r_ways;
    logic [SW-1:0]                r_counter;
    logic [2:0]                   r_h, r_out_h;
    logic [1:0]                   r_m, r_out_m, r_e, r_out_e;
    logic [salc_pkg::TOTAL_W-1:0] r_ht, r_mt, r_et;
    logic [NW-1:0]                r_valid [salc_pkg::SETS];

    logic                         w_next;
    logic [salc_pkg::SET_W-1:0]   p_set;
    logic [TW-1:0]                p_tag;
    logic [NW*TW-1:0]             rd_tags, wr_tags;
    logic [NW*SW-1:0]             rd_stamps, wr_stamps;
    logic [NW-1:0]                row_valid;
    logic                         hit, free;
    logic [salc_pkg::WAY_W-1:0]   hit_w, free_w, lru_w, pick;
    logic                         is_mod;

    always_comb begin
        w_s = ({1'b0, r_cfg_s} > 4'(salc_pkg::SET_BITS_MAX)) ?
              4'(salc_pkg::SET_BITS_MAX) : {1'b0, r_cfg_s};
        w_b = (r_cfg_b == 5'd0) ? 5'd1 : ((r_cfg_b > 5'd16) ? 5'd16 : r_cfg_b);
        w_ways = (r_cfg_e == 3'd0) ? salc_pkg::WCNT_W'(1) :
                 ((32'(r_cfg_e) > 32'(NW)) ? salc_pkg::WCNT_W'(NW) :
                  salc_pkg::WCNT_W'(r_cfg_e));
        w_sh    = 5'(w_s) + w_b;
        w_addr  = i_address[salc_pkg::ADDR_BITS-1:0];
        w_blk   = w_addr >> w_b;
        w_smask = ~({salc_pkg::SET_W{1'b1}} << w_s);
        w_set   = w_blk[salc_pkg::SET_W-1:0] & w_smask;
        w_omask = ~(17'h1ffff << w_b);
        w_off   = {1'b0, w_addr[15:0]} & w_omask;
        w_size  = (i_size == 5'd0) ? 5'd1 : i_size;
        w_end   = w_off + 17'(w_size) - 17'd1;
    end

    assign w_next = r_first && r_cross;
    assign p_set  = !w_next ? r_set : (r_wrap ? '0 : r_set + 1'b1);
    assign p_tag  = (w_next && r_wrap) ? r_tag + 1'b1 : r_tag;
    assign o_st.noop = r_noop;
    assign o_st.more = w_next;
    assign row_valid = r_valid[p_set];
    assign is_mod    = (r_cmd == salc_pkg::CMD_MODIFY);

    always_comb begin
        hit   = 1'b0;
        hit_w = '0;
        free  = 1'b0;
        free_w = '0;
        lru_w = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (w < 32'(r_ways)) begin
                if (row_valid[w] && rd_tags[w*TW +: TW] == p_tag) begin
                    hit   = 1'b1;
                    hit_w = salc_pkg::WAY_W'(w);
                end
                if (!row_valid[w]) begin
                    free   = 1'b1;
                    free_w = salc_pkg::WAY_W'(w);
                end
            end
        end
        for (int w = 1; w < NW; w++) begin
            if (w < 32'(r_ways) &&
                rd_stamps[w*SW +: SW] < rd_stamps[32'(lru_w)*SW +: SW]) begin
                lru_w = salc_pkg::WAY_W'(w);
            end
        end
        pick = hit ? hit_w : (free ? free_w : lru_w);
        wr_tags   = rd_tags;
        wr_stamps = rd_stamps;
        wr_tags[32'(pick)*TW +: TW]   = p_tag;
        wr_stamps[32'(pick)*SW +: SW] = r_counter;
    end

    salc_ram #(.WIDTH(NW * TW), .DEPTH(salc_pkg::SETS)) u_tags (
        .i_clk(i_clk), .i_we(i_dcmd.probe_wr), .i_waddr(p_set), .i_wdata(wr_tags),
        .i_re(i_dcmd.probe_rd), .i_raddr(p_set), .o_rdata(rd_tags)
    );

    salc_ram #(.WIDTH(NW * SW), .DEPTH(salc_pkg::SETS)) u_stamps (
        .i_clk(i_clk), .i_we(i_dcmd.probe_wr), .i_waddr(p_set), .i_wdata(wr_stamps),
        .i_re(i_dcmd.probe_rd), .i_raddr(p_set), .o_rdata(rd_stamps)
    );

    function automatic logic [salc_pkg::TOTAL_W-1:0] sat_add(
        input logic [salc_pkg::TOTAL_W-1:0] a, input logic [2:0] n);
        logic [salc_pkg::TOTAL_W:0] sum;
        sum = {1'b0, a} + (salc_pkg::TOTAL_W + 1)'(n);
        return sum[salc_pkg::TOTAL_W] ? '1 : sum[salc_pkg::TOTAL_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_dcmd.accept) begin
            r_cmd   <= i_cmd;
            r_noop  <= (i_cmd != salc_pkg::CMD_LOAD) && (i_cmd != salc_pkg::CMD_STORE) &&
                       (i_cmd != salc_pkg::CMD_MODIFY);
            r_tag   <= w_addr >> w_sh;
            r_set   <= w_set;
            r_cross <= (w_end > w_omask);
            r_wrap  <= (w_set == w_smask);
            r_ways  <= w_ways;
        end
        if (i_dcmd.load_out) begin
            r_out_h <= r_h;
            r_out_m <= r_m;
            r_out_e <= r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_s   <= 3'd4;
            r_cfg_b   <= 5'd4;
            r_cfg_e   <= 3'd1;
            r_counter <= '0;
            r_ht      <= '0;
            r_mt      <= '0;
            r_et      <= '0;
            r_first   <= 1'b0;
            r_h       <= '0;
            r_m       <= '0;
            r_e       <= '0;
            for (int i = 0; i < salc_pkg::SETS; i++) begin
                r_valid[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    salc_pkg::CFG_SET_BITS:    r_cfg_s <= i_cfg_data[2:0];
                    salc_pkg::CFG_OFFSET_BITS: r_cfg_b <= i_cfg_data;
                    salc_pkg::CFG_WAYS:        r_cfg_e <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_dcmd.accept) begin
                r_counter <= r_counter + 1'b1;
                r_first   <= 1'b1;
                r_h       <= '0;
                r_m       <= '0;
                r_e       <= '0;
            end
            if (i_dcmd.probe_wr) begin
                r_first              <= 1'b0;
                r_valid[p_set][pick] <= 1'b1;
                if (hit) begin
                    r_h <= r_h + (is_mod ? 3'd2 : 3'd1);
                end else begin
                    r_m <= r_m + 2'd1;
                    r_h <= r_h + {2'b00, is_mod};
                    r_e <= r_e + {1'b0, !free};
                end
            end
            if (i_dcmd.load_out && !r_noop) begin
                r_ht <= sat_add(r_ht, r_h);
                r_mt <= sat_add(r_mt, {1'b0, r_m});
                r_et <= sat_add(r_et, {1'b0, r_e});
            end
        end
    end

    assign o_hits_now       = r_out_h;
    assign o_misses_now     = r_out_m;
    assign o_evictions_now  = r_out_e;
    assign o_hit_total      = r_ht;
    assign o_miss_total     = r_mt;
    assign o_eviction_total = r_et;

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h <= 3'd4) else $error("hit count out of range");
    a_noop_no_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dcmd.probe_wr |-> !r_noop) else $error("probe on unknown command");
    a_miss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e <= r_m) else $error("more evictions than misses");
endmodule
